@@ design/periodic_tick_scheduler_macros.svh @@
`ifndef PERIODIC_TICK_SCHEDULER_MACROS_SVH
`define PERIODIC_TICK_SCHEDULER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PTK_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("periodic tick scheduler check failed");

// next-cycle implication, sampled on clk, off during reset
`define PTK_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("periodic tick scheduler check failed");

`endif

@@ design/ptk_pkg.sv @@
package ptk_pkg;

    localparam int TIME_BITS = 64;
    localparam int DUR_BITS  = 32;

    localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - TIME_BITS);
    localparam logic [63:0] DUR_MAX  = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - DUR_BITS);

    localparam logic [2:0] ACT_ADVANCE  = 3'd0;
    localparam logic [2:0] ACT_START    = 3'd1;
    localparam logic [2:0] ACT_STOP     = 3'd2;
    localparam logic [2:0] ACT_ENABLE   = 3'd3;
    localparam logic [2:0] ACT_INTERVAL = 3'd4;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_RUNNING = 2'd1;
    localparam logic [1:0] ST_BACKWARDS   = 2'd2;
    localparam logic [1:0] ST_CANNOT_TICK = 2'd3;

    localparam logic [1:0] REG_CAN_EVER_TICK    = 2'd0;
    localparam logic [1:0] REG_START_ENABLED    = 2'd1;
    localparam logic [1:0] REG_INITIAL_INTERVAL = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] now_ms;
        logic        enable_request;
        logic [31:0] new_interval;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        tick;
        logic [63:0] tick_time;
        logic [31:0] tick_delta;
        logic        enabled_now;
        logic [31:0] interval_now;
    } out_item_t;

endpackage

@@ design/periodic_tick_scheduler.sv @@
// path: an accepted item goes through the input register, then the decision logic,
// then the result register
// throughput: one item per cycle while the output is not stalled; the 64-bit compares
// and the saturating due-time add between the two registers set the cycle time
// reset: running and restart clear, times clear, enabled and interval reload
// from the register reset values (enabled 1, interval 0)
`include "periodic_tick_scheduler_macros.svh"

module periodic_tick_scheduler (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ptk_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output ptk_pkg::out_item_t  out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int TB = ptk_pkg::TIME_BITS;
    localparam int DB = ptk_pkg::DUR_BITS;
    localparam int SW = 65;

    // configuration registers
    logic        can_tick_reg, can_tick_next;
    logic        start_en_reg, start_en_next;
    logic [31:0] init_iv_reg, init_iv_next;

    // scheduler state
    logic          running_reg, running_next;
    logic          enabled_reg, enabled_next;
    logic          restart_reg, restart_next;
    logic [DB-1:0] interval_reg, interval_next;
    logic [TB-1:0] last_seen_reg, last_seen_next;
    logic [TB-1:0] prev_tick_reg, prev_tick_next;
    logic [TB-1:0] next_due_reg, next_due_next;

    // pipeline registers
    logic               s_vld_reg, s_vld_next;
    ptk_pkg::in_item_t  s_item_reg, s_item_next;
    logic               out_vld_reg, out_vld_next;
    ptk_pkg::out_item_t out_reg, out_next;

    logic          advance;
    logic          fire;
    logic          in_take;
    logic          cfg_wr;
    logic [1:0]    cfg_idx;
    logic [TB-1:0] now;
    logic [DB-1:0] new_iv;
    logic [SW-1:0] due_sum;
    logic [TB-1:0] due_time;
    logic [TB-1:0] diff;
    logic [DB-1:0] delta;
    logic          period_hit;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_comb
    begin
        case (cfg_idx)
            ptk_pkg::REG_CAN_EVER_TICK:    prdata = {31'd0, can_tick_reg};
            ptk_pkg::REG_START_ENABLED:    prdata = {31'd0, start_en_reg};
            ptk_pkg::REG_INITIAL_INTERVAL: prdata = init_iv_reg;
            default:                       prdata = 32'd0;
        endcase
    end

    assign advance   = !out_vld_reg || !out_stall;
    assign fire      = s_vld_reg && advance;
    assign in_stall  = s_vld_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_vld_reg;
    assign out_item  = out_reg;

    assign now    = TB'(s_item_reg.now_ms);
    assign new_iv = DB'(s_item_reg.new_interval);

    // saturating due time and delta
    assign due_sum  = SW'(now) + SW'(interval_reg);
    assign due_time = (due_sum > SW'(ptk_pkg::TIME_MAX)) ? TB'(ptk_pkg::TIME_MAX)
                                                         : TB'(due_sum);
    assign diff     = now - prev_tick_reg;
    assign delta    = (SW'(diff) > SW'(ptk_pkg::DUR_MAX)) ? '1 : DB'(diff);

    assign period_hit = (interval_reg == '0)
                     || ((now >= next_due_reg) && (now != prev_tick_reg));

    always_comb
    begin
        s_vld_next  = s_vld_reg;
        s_item_next = s_item_reg;
        if (in_take)
        begin
            s_vld_next  = 1'b1;
            s_item_next = in_item;
        end
        else if (fire)
        begin
            s_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        can_tick_next  = can_tick_reg;
        start_en_next  = start_en_reg;
        init_iv_next   = init_iv_reg;
        running_next   = running_reg;
        enabled_next   = enabled_reg;
        restart_next   = restart_reg;
        interval_next  = interval_reg;
        last_seen_next = last_seen_reg;
        prev_tick_next = prev_tick_reg;
        next_due_next  = next_due_reg;
        out_vld_next   = out_vld_reg;
        out_next       = out_reg;

        if (out_vld_reg && !out_stall)
        begin
            out_vld_next = 1'b0;
        end

        if (fire)
        begin
            out_vld_next          = 1'b1;
            out_next.status       = ptk_pkg::ST_OK;
            out_next.tick         = 1'b0;
            out_next.tick_time    = 64'd0;
            out_next.tick_delta   = 32'd0;

            case (s_item_reg.action)
                ptk_pkg::ACT_ADVANCE:
                begin
                    if (!running_reg)
                    begin
                        out_next.status = ptk_pkg::ST_NOT_RUNNING;
                    end
                    else if (now < last_seen_reg)
                    begin
                        out_next.status = ptk_pkg::ST_BACKWARDS;
                    end
                    else
                    begin
                        last_seen_next = now;
                        if (enabled_reg && (restart_reg || period_hit))
                        begin
                            restart_next       = 1'b0;
                            prev_tick_next     = now;
                            next_due_next      = due_time;
                            out_next.tick      = 1'b1;
                            out_next.tick_time = 64'(now);
                            // first tick after a restart reports no delta
                            out_next.tick_delta = restart_reg ? 32'd0 : 32'(delta);
                        end
                    end
                end
                ptk_pkg::ACT_START:
                begin
                    last_seen_next = now;
                    prev_tick_next = now;
                    next_due_next  = now;
                    running_next   = 1'b1;
                    restart_next   = 1'b1;
                end
                ptk_pkg::ACT_STOP:
                begin
                    running_next = 1'b0;
                end
                ptk_pkg::ACT_ENABLE:
                begin
                    if (s_item_reg.enable_request && !can_tick_reg)
                    begin
                        out_next.status = ptk_pkg::ST_CANNOT_TICK;
                    end
                    else if (enabled_reg != s_item_reg.enable_request)
                    begin
                        enabled_next = s_item_reg.enable_request;
                        restart_next = 1'b1;
                    end
                end
                ptk_pkg::ACT_INTERVAL:
                begin
                    interval_next = new_iv;
                    restart_next  = 1'b1;
                end
                default:
                begin
                end
            endcase

            out_next.enabled_now  = enabled_next;
            out_next.interval_now = 32'(interval_next);
        end

        // a write to a mapped register reloads enable and interval from the new settings
        if (cfg_wr)
        begin
            case (cfg_idx)
                ptk_pkg::REG_CAN_EVER_TICK:
                begin
                    can_tick_next = pwdata[0];
                    enabled_next  = pwdata[0] && start_en_reg;
                    interval_next = DB'(init_iv_reg);
                end
                ptk_pkg::REG_START_ENABLED:
                begin
                    start_en_next = pwdata[0];
                    enabled_next  = can_tick_reg && pwdata[0];
                    interval_next = DB'(init_iv_reg);
                end
                ptk_pkg::REG_INITIAL_INTERVAL:
                begin
                    init_iv_next  = pwdata;
                    enabled_next  = can_tick_reg && start_en_reg;
                    interval_next = DB'(pwdata);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            can_tick_reg  <= 1'b1;
            start_en_reg  <= 1'b1;
            init_iv_reg   <= 32'd0;
            running_reg   <= 1'b0;
            enabled_reg   <= 1'b1;
            restart_reg   <= 1'b0;
            interval_reg  <= '0;
            last_seen_reg <= '0;
            prev_tick_reg <= '0;
            next_due_reg  <= '0;
            s_vld_reg     <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            can_tick_reg  <= can_tick_next;
            start_en_reg  <= start_en_next;
            init_iv_reg   <= init_iv_next;
            running_reg   <= running_next;
            enabled_reg   <= enabled_next;
            restart_reg   <= restart_next;
            interval_reg  <= interval_next;
            last_seen_reg <= last_seen_next;
            prev_tick_reg <= prev_tick_next;
            next_due_reg  <= next_due_next;
            s_vld_reg     <= s_vld_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_item_reg <= s_item_next;
        out_reg    <= out_next;
    end

    `PTK_ASSERT_NOW(a_tick_is_clean, out_vld_reg && out_reg.tick, (out_reg.status == ptk_pkg::ST_OK) && out_reg.enabled_now)
    `PTK_ASSERT_NOW(a_idle_fields_zero, out_vld_reg && !out_reg.tick, (out_reg.tick_time == 64'd0) && (out_reg.tick_delta == 32'd0))
    `PTK_ASSERT_NEXT(a_start_arms, fire && (s_item_reg.action == ptk_pkg::ACT_START), running_reg && restart_reg && out_vld_reg)
    `PTK_ASSERT_NEXT(a_refuse_stopped, fire && !running_reg && (s_item_reg.action == ptk_pkg::ACT_ADVANCE), out_vld_reg && (out_reg.status == ptk_pkg::ST_NOT_RUNNING) && !out_reg.tick)

endmodule

@@ tb/sv/periodic_tick_scheduler_tb.sv @@
`timescale 1ns / 100ps

module periodic_tick_scheduler_tb;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          PHASE_ITEMS = 160;
    localparam logic [1:0]  REG_UNMAPPED = 2'd3;
    localparam logic [2:0]  ACT_SPARE_A  = 3'd5;
    localparam logic [2:0]  ACT_SPARE_B  = 3'd6;
    localparam logic [2:0]  ACT_SPARE_C  = 3'd7;
    localparam logic [63:0] NEAR_TOP     = 64'hFFFF_FFFF_FFFF_FF00;

    class tick_scoreboard;
        logic        tick_allowed;
        logic        enable_at_load;
        logic [31:0] load_interval;

        logic        running;
        logic        enabled;
        logic        restart_pending;
        logic [31:0] interval;
        logic [63:0] last_seen;
        logic [63:0] prev_tick;
        logic [63:0] next_due;

        ptk_pkg::out_item_t expected_q[$];
        int                 mismatches;

        function void reload();
            enabled  = tick_allowed & enable_at_load;
            interval = load_interval;
        endfunction

        function void reset_state();
            tick_allowed    = 1'b1;
            enable_at_load  = 1'b1;
            load_interval   = '0;
            running         = 1'b0;
            restart_pending = 1'b0;
            last_seen       = '0;
            prev_tick       = '0;
            next_due        = '0;
            mismatches      = 0;
            expected_q.delete();
            reload();
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                ptk_pkg::REG_CAN_EVER_TICK:    tick_allowed = val[0];
                ptk_pkg::REG_START_ENABLED:    enable_at_load = val[0];
                ptk_pkg::REG_INITIAL_INTERVAL: load_interval = val;
                default:                       return;
            endcase
            reload();
        endfunction

        function logic [63:0] due_after(logic [63:0] t);
            logic [63:0] iv;
            iv = {32'b0, interval};
            if (ptk_pkg::TIME_MAX - t < iv)
                return ptk_pkg::TIME_MAX;
            return t + iv;
        endfunction

        function logic [31:0] delta_from(logic [63:0] t);
            logic [63:0] d;
            d = (t - prev_tick) & ptk_pkg::TIME_MAX;
            if (d > ptk_pkg::DUR_MAX)
                d = ptk_pkg::DUR_MAX;
            return d[31:0];
        endfunction

        function void note_item(ptk_pkg::in_item_t it);
            ptk_pkg::out_item_t r;
            logic [63:0]        t;
            r = '0;
            r.status = ptk_pkg::ST_OK;
            t = it.now_ms & ptk_pkg::TIME_MAX;
            case (it.action)
                ptk_pkg::ACT_ADVANCE:
                begin
                    if (!running)
                        r.status = ptk_pkg::ST_NOT_RUNNING;
                    else if (t < last_seen)
                        r.status = ptk_pkg::ST_BACKWARDS;
                    else
                    begin
                        last_seen = t;
                        if (enabled)
                        begin
                            if (restart_pending)
                            begin
                                // first tick after a restart reports no delta
                                restart_pending = 1'b0;
                                prev_tick = t;
                                next_due = due_after(t);
                                r.tick = 1'b1;
                                r.tick_time = t;
                            end
                            else if (interval == '0 || (t >= next_due && t != prev_tick))
                            begin
                                r.tick_delta = delta_from(t);
                                prev_tick = t;
                                next_due = due_after(t);
                                r.tick = 1'b1;
                                r.tick_time = t;
                            end
                        end
                    end
                end
                ptk_pkg::ACT_START:
                begin
                    last_seen = t;
                    prev_tick = t;
                    next_due = t;
                    running = 1'b1;
                    restart_pending = 1'b1;
                end
                ptk_pkg::ACT_STOP: running = 1'b0;
                ptk_pkg::ACT_ENABLE:
                begin
                    if (it.enable_request && !tick_allowed)
                        r.status = ptk_pkg::ST_CANNOT_TICK;
                    else if (enabled != it.enable_request)
                    begin
                        enabled = it.enable_request;
                        restart_pending = 1'b1;
                    end
                end
                ptk_pkg::ACT_INTERVAL:
                begin
                    interval = it.new_interval;
                    restart_pending = 1'b1;
                end
                default: ;
            endcase
            r.enabled_now = enabled;
            r.interval_now = interval;
            expected_q.push_back(r);
        endfunction

        function void check_result(ptk_pkg::out_item_t got);
            ptk_pkg::out_item_t exp;
            if (expected_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: result with nothing expected: %h", $realtime, got);
                mismatches++;
                return;
            end
            exp = expected_q.pop_front();
            if (got.status !== exp.status || got.tick !== exp.tick ||
                got.tick_time !== exp.tick_time || got.tick_delta !== exp.tick_delta ||
                got.enabled_now !== exp.enabled_now ||
                got.interval_now !== exp.interval_now)
            begin
                if (mismatches < 10)
                begin
                    $display("%0t: mismatch", $realtime);
                    $display("  expected st=%0d tick=%0d time=%h delta=%h en=%0d iv=%h",
                             exp.status, exp.tick, exp.tick_time, exp.tick_delta,
                             exp.enabled_now, exp.interval_now);
                    $display("  actual   st=%0d tick=%0d time=%h delta=%h en=%0d iv=%h",
                             got.status, got.tick, got.tick_time, got.tick_delta,
                             got.enabled_now, got.interval_now);
                end
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    ptk_pkg::in_item_t  in_item;
    logic               out_valid;
    logic               out_stall;
    ptk_pkg::out_item_t out_item;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    tick_scoreboard sb;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             cycles;
    logic [63:0]    seq_time;

    periodic_tick_scheduler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_item);

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_item(ptk_pkg::in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_item = it;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_item(it);
        @(negedge clk);
    endtask

    task automatic send_action(logic [2:0] act, logic [63:0] t, logic req, logic [31:0] iv);
        ptk_pkg::in_item_t it;
        it.action = act;
        it.now_ms = t;
        it.enable_request = req;
        it.new_interval = iv;
        send_item(it);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.write_reg(idx, val);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // mostly start/advance runs with rising timestamps, plus settings changes and noise
    function automatic ptk_pkg::in_item_t next_random_item();
        ptk_pkg::in_item_t it;
        int                r;
        int                s;
        logic [63:0]       step;
        it.action = ptk_pkg::ACT_ADVANCE;
        it.now_ms = rand64();
        it.enable_request = 1'($urandom_range(1));
        it.new_interval = $urandom;
        r = $urandom_range(99);
        if (r < 60)
        begin
            s = $urandom_range(99);
            if (s < 10)
                step = '0;
            else if (s < 90)
                step = 64'($urandom_range(30));
            else if (s < 96)
                step = {$urandom_range(255), $urandom};
            else
                step = rand64();
            seq_time = seq_time + step;
            it.now_ms = seq_time;
        end
        else if (r < 70)
        begin
            s = $urandom_range(9);
            if (s == 0)
                seq_time = rand64();
            else if (s == 1)
                seq_time = {32'hFFFF_FFFF, $urandom};
            it.action = ptk_pkg::ACT_START;
            it.now_ms = seq_time;
        end
        else if (r < 76)
            it.action = ptk_pkg::ACT_STOP;
        else if (r < 84)
            it.action = ptk_pkg::ACT_ENABLE;
        else if (r < 92)
        begin
            it.action = ptk_pkg::ACT_INTERVAL;
            if ($urandom_range(3) != 0)
                it.new_interval = $urandom_range(40);
        end
        else if (r < 96)
            it.now_ms = seq_time - 64'($urandom_range(1, 50));
        else
            it.action = 3'($urandom_range(7));
        return it;
    endfunction

    task automatic run_phase(logic cet, logic se, logic [31:0] iv, int sp, int rp, int n);
        wait_idle();
        reg_write(ptk_pkg::REG_CAN_EVER_TICK, {31'($urandom_range(32'h7FFF_FFFF)), cet});
        reg_write(ptk_pkg::REG_START_ENABLED, {31'($urandom_range(32'h7FFF_FFFF)), se});
        reg_write(ptk_pkg::REG_INITIAL_INTERVAL, iv);
        send_idle_pct = sp;
        recv_stall_pct = rp;
        // refused enable is reachable right away when ticking is barred
        send_action(ptk_pkg::ACT_ENABLE, rand64(), 1'b1, $urandom);
        repeat (n) send_item(next_random_item());
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cycles = 0;
        seq_time = '0;
        send_idle_pct = 33;
        recv_stall_pct = 79;
        sb = new;
        sb.reset_state();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_action(ptk_pkg::ACT_ADVANCE, 64'd0, 1'b0, '0);
        send_action(ptk_pkg::ACT_STOP, rand64(), 1'b1, $urandom);
        send_action(ptk_pkg::ACT_START, 64'd100, 1'b0, $urandom);
        send_action(ptk_pkg::ACT_ADVANCE, 64'd100, 1'b1, $urandom);
        send_action(ptk_pkg::ACT_ADVANCE, 64'd100, 1'b0, $urandom);
        send_action(ptk_pkg::ACT_ADVANCE, 64'd50, 1'b0, $urandom);
        send_action(ptk_pkg::ACT_INTERVAL, rand64(), 1'b0, 32'd10);
        send_action(ptk_pkg::ACT_ADVANCE, 64'd105, 1'b0, $urandom);
        send_action(ptk_pkg::ACT_ADVANCE, 64'd110, 1'b0, $urandom);
        send_action(ptk_pkg::ACT_ADVANCE, 64'd115, 1'b0, $urandom);
        send_action(ptk_pkg::ACT_ADVANCE, 64'd115, 1'b0, $urandom);
        send_action(ptk_pkg::ACT_ENABLE, rand64(), 1'b0, $urandom);
        send_action(ptk_pkg::ACT_ADVANCE, 64'd200, 1'b1, $urandom);
        send_action(ptk_pkg::ACT_ENABLE, rand64(), 1'b0, $urandom);
        send_action(ptk_pkg::ACT_ENABLE, rand64(), 1'b1, $urandom);
        send_action(ptk_pkg::ACT_ADVANCE, 64'd300, 1'b0, $urandom);
        send_action(ACT_SPARE_A, rand64(), 1'b1, $urandom);
        send_action(ACT_SPARE_B, rand64(), 1'b0, $urandom);
        send_action(ACT_SPARE_C, rand64(), 1'b1, $urandom);
        // due time saturates, then a tick at the very top of the time range
        send_action(ptk_pkg::ACT_INTERVAL, rand64(), 1'b0, 32'hFFFF_FFFF);
        send_action(ptk_pkg::ACT_START, NEAR_TOP, 1'b0, $urandom);
        send_action(ptk_pkg::ACT_ADVANCE, NEAR_TOP, 1'b0, $urandom);
        send_action(ptk_pkg::ACT_ADVANCE, ptk_pkg::TIME_MAX, 1'b0, $urandom);
        // delta saturates with a zero interval and a long gap
        send_action(ptk_pkg::ACT_INTERVAL, rand64(), 1'b0, 32'd0);
        send_action(ptk_pkg::ACT_START, 64'd0, 1'b0, $urandom);
        send_action(ptk_pkg::ACT_ADVANCE, 64'd0, 1'b0, $urandom);
        send_action(ptk_pkg::ACT_ADVANCE, 64'h0000_0100_0000_0000, 1'b0, $urandom);

        wait_idle();
        reg_write(REG_UNMAPPED, $urandom);

        run_phase(1'b1, 1'b1, 32'd0, 33, 79, PHASE_ITEMS);
        run_phase(1'b0, 1'b1, 32'hFFFF_FFFF, 33, 79, PHASE_ITEMS);
        run_phase(1'b1, 1'b0, 32'd7, 79, 33, PHASE_ITEMS);
        run_phase(1'b1, 1'b1, $urandom, 79, 33, PHASE_ITEMS);
        run_phase(1'b0, 1'b0, 32'd1, 0, 0, PHASE_ITEMS);
        run_phase(1'b1, 1'b1, 32'd100, 0, 0, PHASE_ITEMS);

        wait_idle();
        repeat (8) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/ptk_pkg.sv
design/periodic_tick_scheduler.sv
tb/sv/periodic_tick_scheduler_tb.sv
